// File: hw/rtl/trcr_pkg.sv
// ----------------------------------------------------------------------------
// trcr_pkg
// shared widths, register indexes, status codes and result type for the
// train car reorder block
// ----------------------------------------------------------------------------
package trcr_pkg;

  localparam int NUM_CARS   = 32;
  localparam int MAX_TRACKS = 8;

  localparam int CAR_W  = 6;   // car number field
  localparam int TRK_W  = 4;   // track number field
  localparam int STAT_W = 2;
  localparam int NE_W   = 7;   // next expected car, reaches car count + 1
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int IDX_W  = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int TIDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_CAR_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDING_TRACKS = 2'd1;

  localparam logic [CAR_W-1:0] CAR_COUNT_RST      = 6'd32;
  localparam logic [TRK_W-1:0] HOLDING_TRACKS_RST = 4'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_MOVED    = 2'd0,
    ST_NO_TRACK = 2'd1,
    ST_FAILED   = 2'd2,
    ST_BAD_CAR  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CAR_W-1:0] moved_car;
    logic [TRK_W-1:0] from_track;
    logic [TRK_W-1:0] to_track;
    status_t          status;
    logic             last_in_run;
    logic             train_done;
  } result_t;

endpackage

// File: hw/rtl/trcr_if.sv
// ----------------------------------------------------------------------------
// trcr channel interfaces
// valid/ready channels for input cars, results and register writes
// ----------------------------------------------------------------------------
interface trcr_in_if import trcr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CAR_W-1:0] car_number;
  logic             new_train;

  modport source (output valid, output car_number, output new_train, input ready);
  modport sink   (input valid, input car_number, input new_train, output ready);
endinterface

interface trcr_out_if import trcr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CAR_W-1:0]  moved_car;
  logic [TRK_W-1:0]  from_track;
  logic [TRK_W-1:0]  to_track;
  logic [STAT_W-1:0] status;
  logic              last_in_run;
  logic              train_done;

  modport source (output valid, output moved_car, output from_track, output to_track,
                  output status, output last_in_run, output train_done, input ready);
  modport sink   (input valid, input moved_car, input from_track, input to_track,
                  input status, input last_in_run, input train_done, output ready);
endinterface

interface trcr_cfg_if import trcr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/train_car_reorder_holding_tracks_top.sv
// ----------------------------------------------------------------------------
// train_car_reorder_holding_tracks_top
// reorders arriving train cars into ascending order over holding tracks
// ----------------------------------------------------------------------------
// usage:
//   in_ch  : one car per transfer (car_number, new_train); new_train clears
//            the holding state before the car is handled
//   out_ch : one or more results per car; last_in_run marks the final one
//   cfg_ch : register writes (0 car_count, 1 holding_tracks), always ready;
//            the user writes only while the block is idle, not enforced
// sequencing:
//   a car that is rejected, parked or goes straight out is accepted, then
//   evaluated; each held car released behind it adds a car table read and
//   then an emit of its result, since the car table read port is registered;
//   a new car is taken only once the block is back in idle
// reset:
//   synchronous active-low reset clears the held flags, track tails and
//   train status and loads car_count 32, holding_tracks 2; the car table
//   ram itself is never cleared, a car entry is only read while held
// stall:
//   a single output register holds the pending result; while the receiver
//   stalls the sequencer waits before producing the next one, and a new car
//   can still be taken into the block while the last result waits
// ----------------------------------------------------------------------------
module train_car_reorder_holding_tracks_top import trcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  trcr_in_if.sink    in_ch,
  trcr_out_if.source out_ch,
  trcr_cfg_if.sink   cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_READ = 4'b0100,
    S_REL  = 4'b1000
  } state_t;

  // control and train state
  state_t                state_r, state_nxt;
  logic [CAR_W-1:0]      car_r, car_nxt;
  logic [NE_W-1:0]       ne_r, ne_nxt;
  logic                  failed_r, failed_nxt;
  logic                  done_run_r, done_run_nxt;
  logic [NUM_CARS-1:0]   held_r, held_nxt;
  logic [CAR_W-1:0]      tail_r [MAX_TRACKS];
  logic [CAR_W-1:0]      tail_nxt [MAX_TRACKS];
  logic [CAR_W-1:0]      car_count_r;
  logic [TRK_W-1:0]      holding_tracks_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  result_t               res_r, res_nxt;

  // car table: holding track of each held car
  logic [TRK_W-1:0]      track_mem [NUM_CARS];
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [TRK_W-1:0]      mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [TRK_W-1:0]      rd_data_r;

  // evaluation signals
  logic [CAR_W-1:0]      n_eff;
  logic [TRK_W-1:0]      h_eff;
  logic                  out_free;
  logic                  car_held;
  logic                  car_bad;
  logic [TRK_W-1:0]      best;
  logic [CAR_W-1:0]      best_tail;
  logic                  all_held;
  logic                  eval_more;
  logic                  rel_more;
  logic [NE_W-1:0]       ne_inc;
  logic [NE_W-1:0]       car_inc;
  logic [TRK_W-1:0]      rel_tm1;
  logic [TIDX_W-1:0]     rel_tidx;
  logic [NE_W-1:0]       ne_dec;
  logic [CAR_W-1:0]      car_dec;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.moved_car   = res_r.moved_car;
  assign out_ch.from_track  = res_r.from_track;
  assign out_ch.to_track    = res_r.to_track;
  assign out_ch.status      = res_r.status;
  assign out_ch.last_in_run = res_r.last_in_run;
  assign out_ch.train_done  = res_r.train_done;

  // effective register values: car count 0 acts as 1, both clip at the maximum
  always_comb begin
    if (car_count_r == '0) begin
      n_eff = CAR_W'(1);
    end else if (car_count_r > CAR_W'(NUM_CARS)) begin
      n_eff = CAR_W'(NUM_CARS);
    end else begin
      n_eff = car_count_r;
    end
    if (holding_tracks_r > TRK_W'(MAX_TRACKS)) begin
      h_eff = TRK_W'(MAX_TRACKS);
    end else begin
      h_eff = holding_tracks_r;
    end
  end

  assign car_dec  = car_r - CAR_W'(1);
  assign car_held = (car_r != '0) && (car_r <= CAR_W'(NUM_CARS)) &&
                    held_r[car_dec[IDX_W-1:0]];
  assign car_bad  = (car_r == '0) || (car_r > n_eff) ||
                    (NE_W'(car_r) < ne_r) || car_held;

  // track choice: largest tail below the car, else first empty track
  always_comb begin
    best      = '0;
    best_tail = '0;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (TRK_W'(i + 1) <= h_eff) begin
        if (tail_r[i] != '0) begin
          if (car_r > tail_r[i] && tail_r[i] > best_tail) begin
            best      = TRK_W'(i + 1);
            best_tail = tail_r[i];
          end
        end else if (best == '0) begin
          best = TRK_W'(i + 1);
        end
      end
    end
  end

  // the run reaches the end of the train when every car above this one is held
  always_comb begin
    all_held = 1'b1;
    for (int j = 0; j < NUM_CARS; j++) begin
      if (CAR_W'(j) >= car_r && CAR_W'(j) < n_eff && !held_r[j]) begin
        all_held = 1'b0;
      end
    end
  end

  assign car_inc   = NE_W'(car_r) + NE_W'(1);
  assign eval_more = (car_inc <= NE_W'(n_eff)) && held_r[car_r[IDX_W-1:0]];

  assign ne_inc    = ne_r + NE_W'(1);
  assign ne_dec    = ne_r - NE_W'(1);
  assign rel_more  = (ne_inc <= NE_W'(n_eff)) && held_r[ne_r[IDX_W-1:0]];
  assign rel_tm1   = rd_data_r - TRK_W'(1);
  assign rel_tidx  = rel_tm1[TIDX_W-1:0];

  // track number 1..MAX_TRACKS to tail index
  function automatic logic [TIDX_W-1:0] rel_tidx_of(input logic [TRK_W-1:0] trk);
    logic [TRK_W-1:0] tm1;
    tm1 = trk - TRK_W'(1);
    return tm1[TIDX_W-1:0];
  endfunction

  always_comb begin
    state_nxt     = state_r;
    car_nxt       = car_r;
    ne_nxt        = ne_r;
    failed_nxt    = failed_r;
    done_run_nxt  = done_run_r;
    held_nxt      = held_r;
    tail_nxt      = tail_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_we        = 1'b0;
    mem_waddr     = car_dec[IDX_W-1:0];
    mem_wdata     = best;
    mem_re        = 1'b0;
    mem_raddr     = ne_dec[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          car_nxt   = in_ch.car_number;
          state_nxt = S_EVAL;
          if (in_ch.new_train) begin
            held_nxt   = '0;
            ne_nxt     = NE_W'(1);
            failed_nxt = 1'b0;
            for (int k = 0; k < MAX_TRACKS; k++) begin
              tail_nxt[k] = '0;
            end
          end
        end
      end

      S_EVAL: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          res_nxt.moved_car   = car_r;
          res_nxt.from_track  = '0;
          res_nxt.to_track    = '0;
          res_nxt.status      = ST_MOVED;
          res_nxt.last_in_run = 1'b1;
          res_nxt.train_done  = (ne_r > NE_W'(n_eff));
          state_nxt           = S_IDLE;
          if (failed_r) begin
            res_nxt.status = ST_FAILED;
          end else if (car_bad) begin
            res_nxt.status = ST_BAD_CAR;
          end else if (NE_W'(car_r) == ne_r) begin
            // straight to output, then release the held cars behind it
            ne_nxt              = car_inc;
            res_nxt.last_in_run = !eval_more;
            res_nxt.train_done  = all_held;
            done_run_nxt        = all_held;
            if (eval_more) begin
              state_nxt = S_READ;
            end
          end else if (best == '0) begin
            failed_nxt     = 1'b1;
            res_nxt.status = ST_NO_TRACK;
          end else begin
            // park on the chosen track
            mem_we                        = 1'b1;
            held_nxt[car_dec[IDX_W-1:0]]  = 1'b1;
            tail_nxt[rel_tidx_of(best)]   = car_r;
            res_nxt.to_track              = best;
          end
        end
      end

      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_REL;
      end

      S_REL: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          res_nxt.moved_car   = ne_r[CAR_W-1:0];
          res_nxt.from_track  = rd_data_r;
          res_nxt.to_track    = '0;
          res_nxt.status      = ST_MOVED;
          res_nxt.last_in_run = !rel_more;
          res_nxt.train_done  = done_run_r;
          held_nxt[ne_dec[IDX_W-1:0]] = 1'b0;
          if (tail_r[rel_tidx] == ne_r[CAR_W-1:0]) begin
            tail_nxt[rel_tidx] = '0;
          end
          ne_nxt    = ne_inc;
          state_nxt = rel_more ? S_READ : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      ne_r             <= NE_W'(1);
      failed_r         <= 1'b0;
      done_run_r       <= 1'b0;
      held_r           <= '0;
      out_valid_r      <= 1'b0;
      car_count_r      <= CAR_COUNT_RST;
      holding_tracks_r <= HOLDING_TRACKS_RST;
      for (int k = 0; k < MAX_TRACKS; k++) begin
        tail_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      failed_r    <= failed_nxt;
      done_run_r  <= done_run_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      tail_r      <= tail_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_CAR_COUNT: begin
            car_count_r <= cfg_ch.data[CAR_W-1:0];
          end
          REG_HOLDING_TRACKS: begin
            holding_tracks_r <= cfg_ch.data[TRK_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    car_r <= car_nxt;
    res_r <= res_nxt;
  end

  // car table ram, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      track_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= track_mem[mem_raddr];
    end
  end

endmodule
